FILE: src/infix_to_postfix_converter_unit_assert.svh
// assertion macros for the infix to postfix converter
// expects clk_i and rst_ni in the scope of every use
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_ASSERT_SVH

// same-cycle implication
`define ITP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ITP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/itp_pkg.sv
// shared types and codes of the infix to postfix converter
// no dependencies
`timescale 1ns / 1ps

package itp_pkg;

  localparam int unsigned KindW    = 3;
  localparam int unsigned PrecW    = 4;
  localparam int unsigned PayloadW = 16;
  localparam int unsigned ErrW     = 2;

  // token categories
  localparam logic [KindW-1:0] K_LBR = 3'd0;
  localparam logic [KindW-1:0] K_LIT = 3'd1;
  localparam logic [KindW-1:0] K_VAR = 3'd2;
  localparam logic [KindW-1:0] K_BIN = 3'd3;
  localparam logic [KindW-1:0] K_UNA = 3'd4;
  localparam logic [KindW-1:0] K_RBR = 3'd5;
  localparam logic [KindW-1:0] K_END = 3'd6;

  // error codes
  localparam logic [ErrW-1:0] ERR_NONE      = 2'd0;
  localparam logic [ErrW-1:0] ERR_UNMATCHED = 2'd1;
  localparam logic [ErrW-1:0] ERR_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic [KindW-1:0]    kind;
    logic [PrecW-1:0]    prec;
    logic [PayloadW-1:0] payload;
  } entry_t;

  // shift command broadcast to every stack cell
  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctrl_t;

endpackage

FILE: src/infix_to_postfix_converter_unit.sv
// top level of the infix to postfix converter (shunting-yard)
// depends on itp_pkg, itp_stack_cell and infix_to_postfix_converter_unit_assert.svh
`timescale 1ns / 1ps

// Tokens come in one word at a time and leave in postfix order, at most one result
// word per cycle while out_stall_i does not hold the output register. The operator
// stack is a row of STACK_DEPTH cells with its top in cell 0; a push or pop shifts
// the whole row by one place per cycle. in_stall_o is high while a token is held,
// so no new token is taken until the held one has made its pops, its push and its
// result words, and a hold on the output register also holds that work. Overflow,
// unmatched right brackets and the end-of-expression terminator come out as result
// words of their own; last_of_run marks the final result word of each token that
// yields any.

`include "infix_to_postfix_converter_unit_assert.svh"

module infix_to_postfix_converter_unit #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [3:0]  precedence_i,
  input  logic [15:0] token_payload_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  out_kind_o,
  output logic [3:0]  out_precedence_o,
  output logic [15:0] out_payload_o,
  output logic [1:0]  error_code_o,
  output logic        last_of_run_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(STACK_DEPTH);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state_d, state_q;
  logic [CntW-1:0] count_d, count_q;
  itp_pkg::entry_t tok_d, tok_q;

  logic out_valid_d, out_valid_q;
  itp_pkg::entry_t out_e_d, out_e_q;
  logic [itp_pkg::ErrW-1:0] out_err_d, out_err_q;
  logic out_last_d, out_last_q;

  itp_pkg::entry_t stack_e [STACK_DEPTH];
  itp_pkg::stack_ctrl_t ctrl;

  logic in_acc, slot_free, step, done;
  logic emit, emit_last;
  logic [itp_pkg::ErrW-1:0] emit_err;
  itp_pkg::entry_t emit_e, top_e, nxt_e;
  logic empty, full, deep, top_ok, nxt_ok;

  // ---------------------------------------------------------------- stack row
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    itp_pkg::entry_t above, below;
    if (i == 0) begin : g_top
      assign above = tok_q;
    end else begin : g_mid
      assign above = stack_e[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = stack_e[i];
    end else begin : g_up
      assign below = stack_e[i+1];
    end
    itp_stack_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .above_i (above),
      .below_i (below),
      .entry_o (stack_e[i])
    );
  end

  // ----------------------------------------------------------------- control
  assign in_stall_o = (state_q == ST_BUSY);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign step       = (state_q == ST_BUSY) && slot_free;

  assign top_e  = stack_e[0];
  assign nxt_e  = stack_e[1];
  assign empty  = (count_q == '0);
  assign full   = (count_q == CntFull);
  assign deep   = (count_q > CntOne);
  // would the top (or the entry under it) be popped by the held operator
  assign top_ok = !empty && (top_e.kind != itp_pkg::K_LBR) && (top_e.prec >= tok_q.prec);
  assign nxt_ok = deep && (nxt_e.kind != itp_pkg::K_LBR) && (nxt_e.prec >= tok_q.prec);

  always_comb begin
    emit      = 1'b0;
    emit_e    = tok_q;
    emit_err  = itp_pkg::ERR_NONE;
    emit_last = 1'b1;
    ctrl      = '0;
    done      = 1'b0;
    unique case (tok_q.kind)
      itp_pkg::K_LBR: begin
        done = 1'b1;
        if (full) begin
          emit     = 1'b1;
          emit_err = itp_pkg::ERR_OVERFLOW;
        end else begin
          ctrl.push = 1'b1;
        end
      end
      itp_pkg::K_LIT, itp_pkg::K_VAR: begin
        emit = 1'b1;
        done = 1'b1;
      end
      itp_pkg::K_BIN, itp_pkg::K_UNA: begin
        if (top_ok) begin
          emit      = 1'b1;
          emit_e    = top_e;
          ctrl.pop  = 1'b1;
          // last only if the push that follows emits nothing
          emit_last = !nxt_ok;
        end else begin
          done = 1'b1;
          if (full) begin
            emit     = 1'b1;
            emit_err = itp_pkg::ERR_OVERFLOW;
          end else begin
            ctrl.push = 1'b1;
          end
        end
      end
      itp_pkg::K_RBR: begin
        if (!empty && top_e.kind != itp_pkg::K_LBR) begin
          emit      = 1'b1;
          emit_e    = top_e;
          ctrl.pop  = 1'b1;
          // a matching bracket below ends the run silently, an empty stack errors
          emit_last = deep && (nxt_e.kind == itp_pkg::K_LBR);
        end else if (!empty) begin
          ctrl.pop = 1'b1;
          done     = 1'b1;
        end else begin
          emit     = 1'b1;
          emit_err = itp_pkg::ERR_UNMATCHED;
          done     = 1'b1;
        end
      end
      itp_pkg::K_END: begin
        emit = 1'b1;
        if (!empty) begin
          emit_e    = top_e;
          ctrl.pop  = 1'b1;
          emit_last = 1'b0;
        end else begin
          done = 1'b1;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
    if (!step) begin
      emit = 1'b0;
      ctrl = '0;
      done = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    tok_d   = tok_q;
    count_d = count_q;
    if (in_acc) begin
      state_d      = ST_BUSY;
      tok_d        = '{kind: kind_i, prec: precedence_i, payload: token_payload_i};
    end else if (done) begin
      state_d = ST_IDLE;
    end
    if (ctrl.push) begin
      count_d = count_q + CntOne;
    end else if (ctrl.pop) begin
      count_d = count_q - CntOne;
    end
  end

  // ---------------------------------------------------------- output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_e_d     = out_e_q;
    out_err_d   = out_err_q;
    out_last_d  = out_last_q;
    if (slot_free) begin
      out_valid_d = emit;
    end
    if (emit) begin
      out_e_d    = emit_e;
      out_err_d  = emit_err;
      out_last_d = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q      <= tok_d;
    out_e_q    <= out_e_d;
    out_err_q  <= out_err_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign out_kind_o       = out_e_q.kind;
  assign out_precedence_o = out_e_q.prec;
  assign out_payload_o    = out_e_q.payload;
  assign error_code_o     = out_err_q;
  assign last_of_run_o    = out_last_q;

  // --------------------------------------------------------------- assertions
  `ITP_ASSERT_NEXT(a_push_count, ctrl.push, count_q == $past(count_q) + CntOne, "push lost")
  `ITP_ASSERT_NOW(a_ovf_full, emit && emit_err == itp_pkg::ERR_OVERFLOW, full, "overflow early")
  `ITP_ASSERT_NEXT(a_acc_busy, in_acc, in_stall_o, "accepted word not held")
  `ITP_ASSERT_NEXT(a_done_idle, done, !in_stall_o, "no release after done")

endmodule

FILE: src/itp_stack_cell.sv
// one cell of the shifting operator stack
// depends on itp_pkg
`timescale 1ns / 1ps

module itp_stack_cell (
  input  logic                clk_i,
  input  itp_pkg::stack_ctrl_t ctrl_i,
  input  itp_pkg::entry_t     above_i,
  input  itp_pkg::entry_t     below_i,
  output itp_pkg::entry_t     entry_o
);

  itp_pkg::entry_t entry_d, entry_q;

  // push shifts toward the bottom, pop shifts toward the top
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      entry_d = above_i;
    end else if (ctrl_i.pop) begin
      entry_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: tb/sv/tb_infix_to_postfix_converter_unit.sv
// self-checking testbench for infix_to_postfix_converter_unit
// predicts the postfix word stream with its own operator stack; needs itp_pkg and the rtl
`timescale 1ns / 1ps

module tb_infix_to_postfix_converter_unit;

  localparam int unsigned StackDepth    = 16;
  localparam int unsigned RandomTokens  = 420;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned CycleLimit    = 500000;
  localparam int unsigned ReportLimit   = 10;
  localparam logic [itp_pkg::KindW-1:0] K_UNDEF = 3'd7;

  typedef struct packed {
    itp_pkg::entry_t          tok;
    logic [itp_pkg::ErrW-1:0] err;
    logic                     last;
  } postfix_word_t;

  // keeps a private operator stack and the postfix words still owed by the block
  class postfix_tracker #(int unsigned DEPTH = 16);
    itp_pkg::entry_t op_stack[DEPTH];
    int unsigned     fill;
    postfix_word_t   owed_words[$];
    int unsigned     failures;

    function new();
      fill     = 0;
      failures = 0;
    endfunction

    function void append_word(postfix_word_t w);
      owed_words = {owed_words, w};
    endfunction

    function void emit(itp_pkg::entry_t tok, logic [itp_pkg::ErrW-1:0] err);
      append_word('{tok: tok, err: err, last: 1'b0});
    endfunction

    function void pop_top();
      fill--;
      emit(op_stack[fill], itp_pkg::ERR_NONE);
    endfunction

    function void push_or_drop(itp_pkg::entry_t tok);
      if (fill >= DEPTH) begin
        emit(tok, itp_pkg::ERR_OVERFLOW);
      end else begin
        op_stack[fill] = tok;
        fill++;
      end
    endfunction

    function void note_token(itp_pkg::entry_t tok);
      int unsigned   start;
      postfix_word_t tail;
      start = owed_words.size();
      case (tok.kind)
        itp_pkg::K_LBR: push_or_drop(tok);
        itp_pkg::K_LIT, itp_pkg::K_VAR: emit(tok, itp_pkg::ERR_NONE);
        itp_pkg::K_BIN, itp_pkg::K_UNA: begin
          // a stacked left bracket stops popping whatever its precedence
          while (fill > 0 && op_stack[fill-1].kind != itp_pkg::K_LBR &&
                 op_stack[fill-1].prec >= tok.prec)
            pop_top();
          push_or_drop(tok);
        end
        itp_pkg::K_RBR: begin
          while (fill > 0 && op_stack[fill-1].kind != itp_pkg::K_LBR)
            pop_top();
          if (fill > 0) fill--;
          else emit(tok, itp_pkg::ERR_UNMATCHED);
        end
        itp_pkg::K_END: begin
          while (fill > 0)
            pop_top();
          emit(tok, itp_pkg::ERR_NONE);
        end
        default: ;
      endcase
      if (owed_words.size() > start) begin
        tail = owed_words.pop_back();
        tail.last = 1'b1;
        append_word(tail);
      end
    endfunction

    function void check_word(postfix_word_t got);
      postfix_word_t want;
      if (owed_words.size() == 0) begin
        failures++;
        if (failures <= ReportLimit)
          $display("unexpected word: kind %0d prec %0d payload %h err %0d last %0b",
                   got.tok.kind, got.tok.prec, got.tok.payload, got.err, got.last);
        return;
      end
      want = owed_words.pop_front();
      if (got.tok.kind !== want.tok.kind || got.tok.prec !== want.tok.prec ||
          got.tok.payload !== want.tok.payload || got.err !== want.err ||
          got.last !== want.last) begin
        failures++;
        if (failures <= ReportLimit) begin
          $display("word mismatch: expected kind %0d prec %0d payload %h err %0d last %0b",
                   want.tok.kind, want.tok.prec, want.tok.payload, want.err, want.last);
          $display("               got kind %0d prec %0d payload %h err %0d last %0b",
                   got.tok.kind, got.tok.prec, got.tok.payload, got.err, got.last);
        end
      end
    endfunction

    function int unsigned pending();
      return owed_words.size();
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [2:0]  kind_i          = 3'd0;
  logic [3:0]  precedence_i    = 4'd0;
  logic [15:0] token_payload_i = 16'd0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [2:0]  out_kind_o;
  logic [3:0]  out_precedence_o;
  logic [15:0] out_payload_o;
  logic [1:0]  error_code_o;
  logic        last_of_run_o;

  postfix_tracker #(StackDepth) tracker;
  itp_pkg::entry_t token_q[$];
  itp_pkg::entry_t tok;
  postfix_word_t   seen_word;
  int unsigned   sent_count    = 0;
  int unsigned   cycle_count   = 0;
  int unsigned   hold_requests = 0;
  int unsigned   holds_served  = 0;
  int unsigned   hold_left     = 0;
  int unsigned   pick;
  int unsigned   nest;
  int unsigned   lvl;
  bit            in_idle_en    = 1'b1;
  bit            out_idle_en   = 1'b1;
  bit            hold_done     = 1'b0;
  bit            pause_done    = 1'b0;

  infix_to_postfix_converter_unit #(
    .STACK_DEPTH(StackDepth)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .precedence_i    (precedence_i),
    .token_payload_i (token_payload_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_kind_o      (out_kind_o),
    .out_precedence_o(out_precedence_o),
    .out_payload_o   (out_payload_o),
    .error_code_o    (error_code_o),
    .last_of_run_o   (last_of_run_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: check accepted words, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_word.tok.kind    = out_kind_o;
      seen_word.tok.prec    = out_precedence_o;
      seen_word.tok.payload = out_payload_o;
      seen_word.err         = error_code_o;
      seen_word.last        = last_of_run_o;
      tracker.check_word(seen_word);
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left    <= HoldOffCycles;
      out_stall_i  <= 1'b1;
    end else begin
      out_stall_i <= out_idle_en && ($urandom_range(0, 99) < 11);
    end
  end

  function automatic void add_token(itp_pkg::entry_t t);
    token_q = {token_q, t};
  endfunction

  function automatic itp_pkg::entry_t make_token(logic [itp_pkg::KindW-1:0] kind);
    itp_pkg::entry_t t;
    t.kind    = kind;
    t.prec    = 4'($urandom_range(0, 15));
    t.payload = 16'($urandom_range(0, 65535));
    return t;
  endfunction

  function automatic void add_operand(int unsigned depth, int unsigned max_depth);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      add_token(make_token(itp_pkg::K_UNA));
      add_operand(depth, max_depth);
    end else if (r < 4 && depth < max_depth) begin
      add_token(make_token(itp_pkg::K_LBR));
      add_expr(depth + 1, max_depth);
      add_token(make_token(itp_pkg::K_RBR));
    end else begin
      add_token(make_token(r[0] ? itp_pkg::K_LIT : itp_pkg::K_VAR));
    end
  endfunction

  function automatic void add_expr(int unsigned depth, int unsigned max_depth);
    add_operand(depth, max_depth);
    repeat ($urandom_range(0, 3)) begin
      add_token(make_token(itp_pkg::K_BIN));
      add_operand(depth, max_depth);
    end
  endfunction

  // valid stays high from one word to the next unless an idle cycle is drawn
  task automatic send_token(input itp_pkg::entry_t t);
    while (in_idle_en && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= t.kind;
    precedence_i    <= t.prec;
    token_payload_i <= t.payload;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_token(t);
    if (t.kind != K_UNDEF) sent_count++;
  endtask

  task automatic send_tokens();
    foreach (token_q[i]) send_token(token_q[i]);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    tracker = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes, terminator on an empty stack, lone right bracket, unknown kind
    add_token(itp_pkg::entry_t'{kind: itp_pkg::K_LIT, prec: 4'h0, payload: 16'h0000});
    add_token(itp_pkg::entry_t'{kind: itp_pkg::K_VAR, prec: 4'hF, payload: 16'hFFFF});
    add_token(itp_pkg::entry_t'{kind: itp_pkg::K_END, prec: 4'h0, payload: 16'h0000});
    add_token(itp_pkg::entry_t'{kind: itp_pkg::K_RBR, prec: 4'hF, payload: 16'hFFFF});
    add_token(itp_pkg::entry_t'{kind: K_UNDEF, prec: 4'hF, payload: 16'hFFFF});
    // right bracket that pops an operator and then finds no left bracket
    add_token(itp_pkg::entry_t'{kind: itp_pkg::K_LIT, prec: 4'h3, payload: 16'h1234});
    add_token(itp_pkg::entry_t'{kind: itp_pkg::K_BIN, prec: 4'h5, payload: 16'hA5A5});
    add_token(itp_pkg::entry_t'{kind: itp_pkg::K_RBR, prec: 4'h0, payload: 16'h5A5A});
    // fill the stack with left brackets, overflow on two operators, drain all at end
    for (int i = 0; i < StackDepth; i++)
      add_token(itp_pkg::entry_t'{kind: itp_pkg::K_LBR, prec: i[0] ? 4'hF : 4'h0,
                                  payload: 16'(i)});
    add_token(itp_pkg::entry_t'{kind: itp_pkg::K_UNA, prec: 4'hF, payload: 16'hC0DE});
    add_token(itp_pkg::entry_t'{kind: itp_pkg::K_BIN, prec: 4'h0, payload: 16'hBEEF});
    add_token(itp_pkg::entry_t'{kind: itp_pkg::K_END, prec: 4'hF, payload: 16'hFFFF});
    send_tokens();

    sent_count = 0;
    while (sent_count < RandomTokens) begin
      in_idle_en = !(sent_count >= 200 && sent_count < 290);
      out_idle_en <= in_idle_en;
      if (!hold_done && sent_count >= 100) begin
        hold_done = 1'b1;
        hold_requests <= hold_requests + 1;
      end
      if (!pause_done && sent_count >= 320) begin
        pause_done = 1'b1;
        wait_drained();
      end
      token_q.delete();
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        add_expr(0, ($urandom_range(0, 9) == 0) ? 12 : 3);
        add_token(make_token(itp_pkg::K_END));
      end else if (pick < 88) begin
        // nested brackets and a rising precedence chain to push the stack deep
        nest = $urandom_range(0, 18);
        repeat (nest) add_token(make_token(itp_pkg::K_LBR));
        add_operand(0, 1);
        lvl = $urandom_range(0, 3);
        repeat ($urandom_range(0, 18)) begin
          tok = make_token($urandom_range(0, 1) ? itp_pkg::K_BIN : itp_pkg::K_UNA);
          tok.prec = 4'(lvl);
          add_token(tok);
          if (lvl < 15 && $urandom_range(0, 3) != 0) lvl++;
          add_operand(0, 1);
        end
        repeat ($urandom_range(0, nest + 2)) add_token(make_token(itp_pkg::K_RBR));
        add_token(make_token(itp_pkg::K_END));
      end else begin
        repeat ($urandom_range(1, 4)) add_token(make_token(3'($urandom_range(0, 7))));
      end
      send_tokens();
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (tracker.failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
